// File: sv/sgba_pkg.sv
// shared types, codes and boundary statement table for the staggered grid boundary block
package sgba_pkg;

    localparam int MAX_CELLS_X_DEF = 64;
    localparam int MAX_CELLS_Y_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_APPLY = 2'd2;

    localparam logic [1:0] GRID_U = 2'd0;
    localparam logic [1:0] GRID_V = 2'd1;
    localparam logic [1:0] GRID_P = 2'd2;
    localparam logic [1:0] GRID_NONE = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_PERIODIC = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;

    localparam logic [2:0] MODE_NONE     = 3'd0;
    localparam logic [2:0] MODE_NOSLIP   = 3'd1;
    localparam logic [2:0] MODE_FREESLIP = 3'd2;
    localparam logic [2:0] MODE_OUTFLOW  = 3'd3;
    localparam logic [2:0] MODE_PERIODIC = 3'd4;

    localparam logic [2:0] REG_WEST    = 3'd0;
    localparam logic [2:0] REG_EAST    = 3'd1;
    localparam logic [2:0] REG_NORTH   = 3'd2;
    localparam logic [2:0] REG_SOUTH   = 3'd3;
    localparam logic [2:0] REG_CELLS_X = 3'd4;
    localparam logic [2:0] REG_CELLS_Y = 3'd5;

    localparam logic [1:0] SIDE_W = 2'd0;
    localparam logic [1:0] SIDE_E = 2'd1;
    localparam logic [1:0] SIDE_N = 2'd2;
    localparam logic [1:0] SIDE_S = 2'd3;

    localparam logic [1:0] OP_ZERO = 2'd0;
    localparam logic [1:0] OP_COPY = 2'd1;
    localparam logic [1:0] OP_NEG  = 2'd2;

    // coordinate selectors, resolved against the loop position and im/jm
    localparam logic [3:0] C_POS = 4'd0;
    localparam logic [3:0] C_0   = 4'd1;
    localparam logic [3:0] C_1   = 4'd2;
    localparam logic [3:0] C_2   = 4'd3;
    localparam logic [3:0] C_IMM = 4'd4;
    localparam logic [3:0] C_IM  = 4'd5;
    localparam logic [3:0] C_IMP = 4'd6;
    localparam logic [3:0] C_JMM = 4'd7;
    localparam logic [3:0] C_JM  = 4'd8;
    localparam logic [3:0] C_JMP = 4'd9;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] grid_sel;
        logic [6:0] col;
        logic [6:0] row;
        logic signed [31:0] cell_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] src_grid;
        logic [3:0] src_x;
        logic [3:0] src_y;
        logic [1:0] dst_grid;
        logic [3:0] dst_x;
        logic [3:0] dst_y;
    } stmt_t;

    function automatic stmt_t mk(input logic [1:0] op, input logic [1:0] sg,
                                 input logic [3:0] sx, input logic [3:0] sy,
                                 input logic [1:0] dg, input logic [3:0] dx,
                                 input logic [3:0] dy);
        stmt_t s;
        s.op = op; s.src_grid = sg; s.src_x = sx; s.src_y = sy;
        s.dst_grid = dg; s.dst_x = dx; s.dst_y = dy;
        return s;
    endfunction

    function automatic logic [2:0] stmt_count(input logic [1:0] side, input logic [2:0] mode);
        logic [2:0] n;
        n = 3'd0;
        if (mode == MODE_NOSLIP || mode == MODE_FREESLIP || mode == MODE_OUTFLOW) begin
            n = 3'd2;
        end else if (mode == MODE_PERIODIC && (side == SIDE_W || side == SIDE_N)) begin
            n = 3'd6;
        end
        return n;
    endfunction

    function automatic logic first_pos(input logic [1:0] side, input logic [2:0] mode);
        logic f;
        unique case (side)
            SIDE_W, SIDE_E: f = 1'b1;
            SIDE_N: f = (mode == MODE_OUTFLOW || mode == MODE_PERIODIC);
            default: f = (mode == MODE_OUTFLOW);
        endcase
        return f;
    endfunction

    function automatic stmt_t stmt_of(input logic [1:0] side, input logic [2:0] mode,
                                      input logic [2:0] k);
        stmt_t s;
        logic [1:0] op1;
        op1 = (mode == MODE_NOSLIP) ? OP_NEG : OP_COPY;
        s = mk(OP_ZERO, GRID_U, C_0, C_0, GRID_U, C_0, C_0);
        unique case (side)
            SIDE_W: begin
                if (mode == MODE_PERIODIC) begin
                    unique case (k)
                        3'd0: s = mk(OP_COPY, GRID_U, C_IMM, C_POS, GRID_U, C_0, C_POS);
                        3'd1: s = mk(OP_COPY, GRID_U, C_1, C_POS, GRID_U, C_IM, C_POS);
                        3'd2: s = mk(OP_COPY, GRID_P, C_IM, C_POS, GRID_P, C_1, C_POS);
                        3'd3: s = mk(OP_COPY, GRID_V, C_IMM, C_POS, GRID_V, C_0, C_POS);
                        3'd4: s = mk(OP_COPY, GRID_V, C_IM, C_POS, GRID_V, C_1, C_POS);
                        default: s = mk(OP_COPY, GRID_V, C_2, C_POS, GRID_V, C_IMP, C_POS);
                    endcase
                end else if (k == 3'd0) begin
                    s = mk((mode == MODE_OUTFLOW) ? OP_COPY : OP_ZERO,
                           GRID_U, C_1, C_POS, GRID_U, C_0, C_POS);
                end else begin
                    s = mk(op1, GRID_V, C_1, C_POS, GRID_V, C_0, C_POS);
                end
            end
            SIDE_E: begin
                if (k == 3'd0) begin
                    s = mk((mode == MODE_OUTFLOW) ? OP_COPY : OP_ZERO,
                           GRID_U, C_IMM, C_POS, GRID_U, C_IM, C_POS);
                end else begin
                    s = mk(op1, GRID_V, C_IM, C_POS, GRID_V, C_IMP, C_POS);
                end
            end
            SIDE_N: begin
                if (mode == MODE_PERIODIC) begin
                    unique case (k)
                        3'd0: s = mk(OP_COPY, GRID_U, C_POS, C_JMM, GRID_U, C_POS, C_0);
                        3'd1: s = mk(OP_COPY, GRID_U, C_POS, C_1, GRID_U, C_POS, C_JM);
                        3'd2: s = mk(OP_COPY, GRID_U, C_POS, C_2, GRID_U, C_POS, C_JMP);
                        3'd3: s = mk(OP_COPY, GRID_P, C_POS, C_JM, GRID_P, C_POS, C_1);
                        3'd4: s = mk(OP_COPY, GRID_V, C_POS, C_JMM, GRID_V, C_POS, C_0);
                        default: s = mk(OP_COPY, GRID_V, C_POS, C_JM, GRID_V, C_POS, C_1);
                    endcase
                end else if (mode == MODE_OUTFLOW) begin
                    if (k == 3'd0) begin
                        s = mk(OP_COPY, GRID_U, C_POS, C_JM, GRID_U, C_POS, C_JMP);
                    end else begin
                        s = mk(OP_COPY, GRID_V, C_POS, C_JMM, GRID_V, C_POS, C_JM);
                    end
                end else if (k == 3'd0) begin
                    s = mk(OP_ZERO, GRID_V, C_POS, C_JM, GRID_V, C_POS, C_JM);
                end else begin
                    s = mk(op1, GRID_U, C_POS, C_JM, GRID_U, C_POS, C_JMP);
                end
            end
            default: begin
                if (mode == MODE_OUTFLOW) begin
                    if (k == 3'd0) begin
                        s = mk(OP_COPY, GRID_U, C_POS, C_1, GRID_U, C_POS, C_0);
                    end else begin
                        s = mk(OP_COPY, GRID_V, C_POS, C_1, GRID_V, C_POS, C_0);
                    end
                end else if (k == 3'd0) begin
                    s = mk(OP_ZERO, GRID_V, C_POS, C_1, GRID_V, C_POS, C_0);
                end else begin
                    s = mk(op1, GRID_U, C_POS, C_1, GRID_U, C_POS, C_0);
                end
            end
        endcase
        return s;
    endfunction

endpackage

// File: sv/staggered_grid_boundary_apply.sv
// staggered u/v/p grid store with cell access and boundary pass
// cell write or read: accepted in idle, then the result register loads once the output is free
// apply: each boundary statement takes a memory read, then a write back; the sequencer
//   also steps past each inactive side; e.g. west periodic walks 6*jm statements
// half-periodic apply answers without a boundary pass; the result waits in an output register
// reset (aresetn, synchronous) clears control and config; grid contents stay undefined
module staggered_grid_boundary_apply #(
    parameter int MAX_CELLS_X = sgba_pkg::MAX_CELLS_X_DEF,
    parameter int MAX_CELLS_Y = sgba_pkg::MAX_CELLS_Y_DEF,
    parameter int VALUE_BITS  = sgba_pkg::VALUE_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sgba_pkg::in_t   s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output sgba_pkg::out_t  m_payload,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [6:0]      cfg_data
);
    import sgba_pkg::*;

    localparam int MAXC   = (MAX_CELLS_X > MAX_CELLS_Y) ? MAX_CELLS_X : MAX_CELLS_Y;
    localparam int CW     = $clog2(MAXC + 2);
    localparam int EW     = ((CW > 7) ? CW : 7) + 1;
    localparam int STRIDE = MAX_CELLS_X + 2;
    localparam int DEPTH  = (MAX_CELLS_X + 2) * (MAX_CELLS_Y + 2);
    localparam int AW     = $clog2(DEPTH);
    localparam int VB     = VALUE_BITS;
    localparam int XW     = ((VB > 32) ? VB : 32) + 1;
    localparam logic [AW-1:0] STRIDE_A = AW'(STRIDE);
    localparam logic [EW-1:0] MAXX_E   = EW'(MAX_CELLS_X);
    localparam logic [EW-1:0] MAXY_E   = EW'(MAX_CELLS_Y);
    localparam logic signed [XW-1:0] VMAX = {{(XW - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN = ~VMAX;
    localparam logic signed [XW-1:0] RMAX = {{(XW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0] RMIN = ~RMAX;
    localparam logic [VB-1:0] VNEG_MIN = {1'b1, {(VB - 1){1'b0}}};
    localparam logic [VB-1:0] VPOS_MAX = {1'b0, {(VB - 1){1'b1}}};

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_RESULT   = 2'd1;
    localparam logic [1:0] ST_APPLY_RD = 2'd2;
    localparam logic [1:0] ST_APPLY_WR = 2'd3;

    logic [2:0] west_reg, east_reg, north_reg, south_reg;
    logic [6:0] cells_x_reg, cells_y_reg;

    logic [1:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       is_read_reg, is_read_next;
    logic [1:0] rsel_reg, rsel_next;
    logic       m_valid_reg, m_valid_next;
    out_t       m_payload_reg, m_payload_next;

    logic [EW-1:0] cx_e, cy_e;
    logic [CW-1:0] im, jm;
    logic [EW-1:0] im_p1_e, jm_p1_e;

    logic          seq_start, seq_step, seq_busy, seq_valid;
    stmt_t         stmt;
    logic [CW-1:0] src_col, src_row, dst_col, dst_row;

    logic [AW-1:0] item_addr, src_addr, dst_addr;
    logic [AW-1:0] raddr, waddr;
    logic [VB-1:0] wdata, rd_sel, neg_val;
    logic [2:0]    we;
    logic          re;
    logic [VB-1:0] rdata_u, rdata_v, rdata_p;

    logic signed [XW-1:0] wr_ext, wr_sat, rd_ext, rd_sat;
    logic                 range_bad, apply_bad;

    // clamp cell counts to the supported range
    assign cx_e = EW'(cells_x_reg);
    assign cy_e = EW'(cells_y_reg);
    assign im   = CW'((cx_e < EW'(2)) ? EW'(2) : ((cx_e > MAXX_E) ? MAXX_E : cx_e));
    assign jm   = CW'((cy_e < EW'(2)) ? EW'(2) : ((cy_e > MAXY_E) ? MAXY_E : cy_e));
    assign im_p1_e = EW'(im) + EW'(1);
    assign jm_p1_e = EW'(jm) + EW'(1);

    assign range_bad = (s_payload.grid_sel == GRID_NONE)
                    || (EW'(s_payload.col) > im_p1_e)
                    || (EW'(s_payload.row) > jm_p1_e);
    assign apply_bad = ((west_reg == MODE_PERIODIC) != (east_reg == MODE_PERIODIC))
                    || ((north_reg == MODE_PERIODIC) != (south_reg == MODE_PERIODIC));

    assign item_addr = AW'(s_payload.row) * STRIDE_A + AW'(s_payload.col);
    assign src_addr  = AW'(src_row) * STRIDE_A + AW'(src_col);
    assign dst_addr  = AW'(dst_row) * STRIDE_A + AW'(dst_col);

    // write saturation to the stored width
    assign wr_ext = XW'(s_payload.cell_value);
    assign wr_sat = (wr_ext > VMAX) ? VMAX : ((wr_ext < VMIN) ? VMIN : wr_ext);

    always_comb begin
        unique case (rsel_reg)
            GRID_U:  rd_sel = rdata_u;
            GRID_V:  rd_sel = rdata_v;
            default: rd_sel = rdata_p;
        endcase
    end

    assign rd_ext  = {{(XW - VB){rd_sel[VB-1]}}, rd_sel};
    assign rd_sat  = (rd_ext > RMAX) ? RMAX : ((rd_ext < RMIN) ? RMIN : rd_ext);
    assign neg_val = (rd_sel == VNEG_MIN) ? VPOS_MAX : (VB'(0) - rd_sel);

    sgba_seq #(.CW(CW)) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (seq_start),
        .step       (seq_step),
        .west_mode  (west_reg),
        .east_mode  (east_reg),
        .north_mode (north_reg),
        .south_mode (south_reg),
        .im         (im),
        .jm         (jm),
        .busy       (seq_busy),
        .stmt_valid (seq_valid),
        .stmt       (stmt),
        .src_col    (src_col),
        .src_row    (src_row),
        .dst_col    (dst_col),
        .dst_row    (dst_row)
    );

    sgba_grid_mem #(.VW(VB), .DEPTH(DEPTH), .AW(AW)) u_mem_u (
        .aclk(aclk), .we(we[0]), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rdata_u)
    );
    sgba_grid_mem #(.VW(VB), .DEPTH(DEPTH), .AW(AW)) u_mem_v (
        .aclk(aclk), .we(we[1]), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rdata_v)
    );
    sgba_grid_mem #(.VW(VB), .DEPTH(DEPTH), .AW(AW)) u_mem_p (
        .aclk(aclk), .we(we[2]), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rdata_p)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        is_read_next   = is_read_reg;
        rsel_next      = rsel_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        seq_start      = 1'b0;
        seq_step       = 1'b0;
        we             = 3'b000;
        re             = 1'b0;
        raddr          = item_addr;
        waddr          = item_addr;
        wdata          = wr_sat[VB-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next  = STAT_OK;
                    is_read_next = 1'b0;
                    state_next   = ST_RESULT;
                    if (s_payload.command == CMD_WRITE || s_payload.command == CMD_READ) begin
                        if (range_bad) begin
                            status_next = STAT_RANGE;
                        end else if (s_payload.command == CMD_WRITE) begin
                            we[s_payload.grid_sel] = 1'b1;
                        end else begin
                            re           = 1'b1;
                            rsel_next    = s_payload.grid_sel;
                            is_read_next = 1'b1;
                        end
                    end else if (s_payload.command == CMD_APPLY) begin
                        if (apply_bad) begin
                            status_next = STAT_PERIODIC;
                        end else begin
                            seq_start  = 1'b1;
                            state_next = ST_APPLY_RD;
                        end
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.status     = status_reg;
                    m_payload_next.read_value = is_read_reg ? rd_sat[31:0] : 32'sd0;
                    state_next                = ST_IDLE;
                end
            end
            ST_APPLY_RD: begin
                if (!seq_busy) begin
                    state_next = ST_RESULT;
                end else if (seq_valid) begin
                    re         = 1'b1;
                    raddr      = src_addr;
                    rsel_next  = stmt.src_grid;
                    state_next = ST_APPLY_WR;
                end
            end
            default: begin
                // write back the modified value, then move to the next statement
                waddr = dst_addr;
                unique case (stmt.op)
                    OP_ZERO: wdata = '0;
                    OP_NEG:  wdata = neg_val;
                    default: wdata = rd_sel;
                endcase
                we[stmt.dst_grid] = 1'b1;
                seq_step   = 1'b1;
                state_next = ST_APPLY_RD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            west_reg    <= MODE_NONE;
            east_reg    <= MODE_NONE;
            north_reg   <= MODE_NONE;
            south_reg   <= MODE_NONE;
            cells_x_reg <= 7'd64;
            cells_y_reg <= 7'd64;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_WEST:    west_reg    <= cfg_data[2:0];
                    REG_EAST:    east_reg    <= cfg_data[2:0];
                    REG_NORTH:   north_reg   <= cfg_data[2:0];
                    REG_SOUTH:   south_reg   <= cfg_data[2:0];
                    REG_CELLS_X: cells_x_reg <= cfg_data;
                    REG_CELLS_Y: cells_y_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        is_read_reg   <= is_read_next;
        rsel_reg      <= rsel_next;
        m_payload_reg <= m_payload_next;
    end
endmodule

// File: sv/sgba_grid_mem.sv
// one grid store: synchronous memory, one write and one registered read port
module sgba_grid_mem #(
    parameter int VW    = 32,
    parameter int DEPTH = 4356,
    parameter int AW    = 13
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [VW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [VW-1:0] rdata
);
    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/sgba_seq.sv
// boundary walk sequencer: side, position and statement counters
module sgba_seq #(
    parameter int CW = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                step,
    input  logic [2:0]          west_mode,
    input  logic [2:0]          east_mode,
    input  logic [2:0]          north_mode,
    input  logic [2:0]          south_mode,
    input  logic [CW-1:0]       im,
    input  logic [CW-1:0]       jm,
    output logic                busy,
    output logic                stmt_valid,
    output sgba_pkg::stmt_t     stmt,
    output logic [CW-1:0]       src_col,
    output logic [CW-1:0]       src_row,
    output logic [CW-1:0]       dst_col,
    output logic [CW-1:0]       dst_row
);
    import sgba_pkg::*;

    localparam logic SQ_IDLE = 1'b0;
    localparam logic SQ_RUN  = 1'b1;

    logic          state_reg, state_next;
    logic [1:0]    side_reg, side_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [2:0]    k_reg, k_next;
    logic [2:0]    cur_mode, nxt_mode;
    logic [1:0]    nxt_side;
    logic [2:0]    n_stmt;
    logic [CW-1:0] last_pos;

    function automatic logic [2:0] mode_of(input logic [1:0] s, input logic [2:0] w,
                                           input logic [2:0] e, input logic [2:0] n,
                                           input logic [2:0] so);
        logic [2:0] m;
        unique case (s)
            SIDE_W:  m = w;
            SIDE_E:  m = e;
            SIDE_N:  m = n;
            default: m = so;
        endcase
        return m;
    endfunction

    function automatic logic [CW-1:0] coord(input logic [3:0] c, input logic [CW-1:0] p,
                                            input logic [CW-1:0] i, input logic [CW-1:0] j);
        logic [CW-1:0] r;
        unique case (c)
            C_POS:   r = p;
            C_0:     r = '0;
            C_1:     r = CW'(1);
            C_2:     r = CW'(2);
            C_IMM:   r = i - CW'(1);
            C_IM:    r = i;
            C_IMP:   r = i + CW'(1);
            C_JMM:   r = j - CW'(1);
            C_JM:    r = j;
            C_JMP:   r = j + CW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    assign cur_mode = mode_of(side_reg, west_mode, east_mode, north_mode, south_mode);
    assign nxt_side = side_reg + 2'd1;
    assign nxt_mode = mode_of(nxt_side, west_mode, east_mode, north_mode, south_mode);
    assign n_stmt   = stmt_count(side_reg, cur_mode);
    assign last_pos = (side_reg == SIDE_W || side_reg == SIDE_E) ? jm : im;

    assign busy       = (state_reg == SQ_RUN);
    assign stmt_valid = busy && (n_stmt != 3'd0);
    assign stmt       = stmt_of(side_reg, cur_mode, k_reg);
    assign src_col    = coord(stmt.src_x, pos_reg, im, jm);
    assign src_row    = coord(stmt.src_y, pos_reg, im, jm);
    assign dst_col    = coord(stmt.dst_x, pos_reg, im, jm);
    assign dst_row    = coord(stmt.dst_y, pos_reg, im, jm);

    always_comb begin
        logic adv_side;
        adv_side   = 1'b0;
        state_next = state_reg;
        side_next  = side_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        if (state_reg == SQ_IDLE) begin
            if (start) begin
                state_next = SQ_RUN;
                side_next  = SIDE_W;
                pos_next   = CW'(first_pos(SIDE_W, west_mode));
                k_next     = 3'd0;
            end
        end else if (n_stmt == 3'd0) begin
            adv_side = 1'b1;
        end else if (step) begin
            if (k_reg == n_stmt - 3'd1) begin
                k_next = 3'd0;
                if (pos_reg == last_pos) begin
                    adv_side = 1'b1;
                end else begin
                    pos_next = pos_reg + CW'(1);
                end
            end else begin
                k_next = k_reg + 3'd1;
            end
        end
        if (adv_side) begin
            k_next = 3'd0;
            if (side_reg == SIDE_S) begin
                state_next = SQ_IDLE;
            end else begin
                side_next = nxt_side;
                pos_next  = CW'(first_pos(nxt_side, nxt_mode));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            side_reg  <= SIDE_W;
            pos_reg   <= '0;
            k_reg     <= 3'd0;
        end else begin
            state_reg <= state_next;
            side_reg  <= side_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
        end
    end
endmodule

// File: test/sgba_checker.sv
// checker for the staggered grid block: mirrors the grids, predicts each result and compares
module sgba_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  sgba_pkg::in_t  s_payload,
    input  logic           m_valid,
    input  logic           m_ready,
    input  sgba_pkg::out_t m_payload,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [6:0]     cfg_data,
    output int             fail_count,
    output int             pending
);
    import sgba_pkg::*;

    localparam int STRIDE = MAX_CELLS_X_DEF + 2;
    localparam int DEPTH  = (MAX_CELLS_X_DEF + 2) * (MAX_CELLS_Y_DEF + 2);
    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;

    logic signed [31:0] u_cells [DEPTH];
    logic signed [31:0] v_cells [DEPTH];
    logic signed [31:0] p_cells [DEPTH];
    logic [2:0] west_m, east_m, north_m, south_m;
    logic [6:0] cells_x, cells_y;
    out_t expected_results [$];

    function automatic logic signed [31:0] cell_rd(logic [1:0] g, int i, int j);
        case (g)
            GRID_U: return u_cells[j * STRIDE + i];
            GRID_V: return v_cells[j * STRIDE + i];
            default: return p_cells[j * STRIDE + i];
        endcase
    endfunction

    function automatic void cell_wr(logic [1:0] g, int i, int j, logic signed [31:0] x);
        case (g)
            GRID_U: u_cells[j * STRIDE + i] = x;
            GRID_V: v_cells[j * STRIDE + i] = x;
            default: p_cells[j * STRIDE + i] = x;
        endcase
    endfunction

    function automatic logic signed [31:0] neg_sat(logic signed [31:0] x);
        return (x == VMIN) ? VMAX : -x;
    endfunction

    function automatic int clamp_cells(logic [6:0] n, int hi);
        if (n < 2) return 2;
        if (n > hi) return hi;
        return n;
    endfunction

    function automatic void boundary_pass(int im, int jm);
        int first;
        for (int j = 1; j <= jm; j++) begin
            case (west_m)
                MODE_NOSLIP: begin
                    cell_wr(GRID_U, 0, j, 0);
                    cell_wr(GRID_V, 0, j, neg_sat(cell_rd(GRID_V, 1, j)));
                end
                MODE_FREESLIP: begin
                    cell_wr(GRID_U, 0, j, 0);
                    cell_wr(GRID_V, 0, j, cell_rd(GRID_V, 1, j));
                end
                MODE_OUTFLOW: begin
                    cell_wr(GRID_U, 0, j, cell_rd(GRID_U, 1, j));
                    cell_wr(GRID_V, 0, j, cell_rd(GRID_V, 1, j));
                end
                MODE_PERIODIC: begin
                    cell_wr(GRID_U, 0, j, cell_rd(GRID_U, im - 1, j));
                    cell_wr(GRID_U, im, j, cell_rd(GRID_U, 1, j));
                    cell_wr(GRID_P, 1, j, cell_rd(GRID_P, im, j));
                    cell_wr(GRID_V, 0, j, cell_rd(GRID_V, im - 1, j));
                    cell_wr(GRID_V, 1, j, cell_rd(GRID_V, im, j));
                    cell_wr(GRID_V, im + 1, j, cell_rd(GRID_V, 2, j));
                end
                default: ;
            endcase
        end
        for (int j = 1; j <= jm; j++) begin
            case (east_m)
                MODE_NOSLIP: begin
                    cell_wr(GRID_U, im, j, 0);
                    cell_wr(GRID_V, im + 1, j, neg_sat(cell_rd(GRID_V, im, j)));
                end
                MODE_FREESLIP: begin
                    cell_wr(GRID_U, im, j, 0);
                    cell_wr(GRID_V, im + 1, j, cell_rd(GRID_V, im, j));
                end
                MODE_OUTFLOW: begin
                    cell_wr(GRID_U, im, j, cell_rd(GRID_U, im - 1, j));
                    cell_wr(GRID_V, im + 1, j, cell_rd(GRID_V, im, j));
                end
                default: ;
            endcase
        end
        first = (north_m == MODE_OUTFLOW || north_m == MODE_PERIODIC) ? 1 : 0;
        for (int i = first; i <= im; i++) begin
            case (north_m)
                MODE_NOSLIP: begin
                    cell_wr(GRID_V, i, jm, 0);
                    cell_wr(GRID_U, i, jm + 1, neg_sat(cell_rd(GRID_U, i, jm)));
                end
                MODE_FREESLIP: begin
                    cell_wr(GRID_V, i, jm, 0);
                    cell_wr(GRID_U, i, jm + 1, cell_rd(GRID_U, i, jm));
                end
                MODE_OUTFLOW: begin
                    cell_wr(GRID_U, i, jm + 1, cell_rd(GRID_U, i, jm));
                    cell_wr(GRID_V, i, jm, cell_rd(GRID_V, i, jm - 1));
                end
                MODE_PERIODIC: begin
                    cell_wr(GRID_U, i, 0, cell_rd(GRID_U, i, jm - 1));
                    cell_wr(GRID_U, i, jm, cell_rd(GRID_U, i, 1));
                    cell_wr(GRID_U, i, jm + 1, cell_rd(GRID_U, i, 2));
                    cell_wr(GRID_P, i, 1, cell_rd(GRID_P, i, jm));
                    cell_wr(GRID_V, i, 0, cell_rd(GRID_V, i, jm - 1));
                    cell_wr(GRID_V, i, 1, cell_rd(GRID_V, i, jm));
                end
                default: ;
            endcase
        end
        first = (south_m == MODE_OUTFLOW) ? 1 : 0;
        for (int i = first; i <= im; i++) begin
            case (south_m)
                MODE_NOSLIP: begin
                    cell_wr(GRID_V, i, 0, 0);
                    cell_wr(GRID_U, i, 0, neg_sat(cell_rd(GRID_U, i, 1)));
                end
                MODE_FREESLIP: begin
                    cell_wr(GRID_V, i, 0, 0);
                    cell_wr(GRID_U, i, 0, cell_rd(GRID_U, i, 1));
                end
                MODE_OUTFLOW: begin
                    cell_wr(GRID_U, i, 0, cell_rd(GRID_U, i, 1));
                    cell_wr(GRID_V, i, 0, cell_rd(GRID_V, i, 1));
                end
                default: ;
            endcase
        end
    endfunction

    function automatic out_t predict_item(in_t it);
        out_t r;
        int im, jm;
        logic ew_bad, ns_bad;
        r.read_value = 0;
        r.status = STAT_OK;
        im = clamp_cells(cells_x, MAX_CELLS_X_DEF);
        jm = clamp_cells(cells_y, MAX_CELLS_Y_DEF);
        if (it.command == CMD_WRITE || it.command == CMD_READ) begin
            if (it.grid_sel == GRID_NONE || it.col > im + 1 || it.row > jm + 1) begin
                r.status = STAT_RANGE;
            end else if (it.command == CMD_WRITE) begin
                cell_wr(it.grid_sel, it.col, it.row, it.cell_value);
            end else begin
                r.read_value = cell_rd(it.grid_sel, it.col, it.row);
            end
        end else if (it.command == CMD_APPLY) begin
            ew_bad = (west_m == MODE_PERIODIC) != (east_m == MODE_PERIODIC);
            ns_bad = (north_m == MODE_PERIODIC) != (south_m == MODE_PERIODIC);
            if (ew_bad || ns_bad) begin
                r.status = STAT_PERIODIC;
            end else begin
                boundary_pass(im, jm);
            end
        end
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            west_m = MODE_NONE;
            east_m = MODE_NONE;
            north_m = MODE_NONE;
            south_m = MODE_NONE;
            cells_x = 7'd64;
            cells_y = 7'd64;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_WEST:    west_m = cfg_data[2:0];
                    REG_EAST:    east_m = cfg_data[2:0];
                    REG_NORTH:   north_m = cfg_data[2:0];
                    REG_SOUTH:   south_m = cfg_data[2:0];
                    REG_CELLS_X: cells_x = cfg_data;
                    REG_CELLS_Y: cells_y = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_item(s_payload));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_payload);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_payload.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 want.read_value, m_payload.read_value);
                        fail_count++;
                    end
                    if (m_payload.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_payload.status);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// File: test/tb_staggered_grid_boundary_apply.sv
// top of the staggered grid block testbench: stimulus, stalls and verdict
module tb_staggered_grid_boundary_apply;
    import sgba_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [6:0] cfg_data;
    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int span_x, span_y;

    staggered_grid_boundary_apply dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sgba_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_staggered_grid_boundary_apply NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input in_t it);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_payload = it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic cell_op(input logic [1:0] cmd, input logic [1:0] g, input int c, input int r,
                           input logic [31:0] x);
        in_t it;
        it.command = cmd;
        it.grid_sel = g;
        it.col = 7'(c);
        it.row = 7'(r);
        it.cell_value = x;
        send(it);
    endtask

    // only while idle: every result back and a few spare cycles
    task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_CELLS_X) span_x = (val < 2) ? 2 : (val > 64) ? 64 : val;
        if (idx == REG_CELLS_Y) span_y = (val < 2) ? 2 : (val > 64) ? 64 : val;
    endtask

    task automatic set_modes(input logic [6:0] w, input logic [6:0] e, input logic [6:0] n,
                             input logic [6:0] s);
        write_reg(REG_WEST, w);
        write_reg(REG_EAST, e);
        write_reg(REG_NORTH, n);
        write_reg(REG_SOUTH, s);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(3) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        logic [1:0] cmd, g;
        int c, r, k;
        k = $urandom_range(99);
        g = 2'($urandom_range(2));
        c = $urandom_range(span_x + 1);
        r = $urandom_range(span_y + 1);
        if (k < 45) cmd = CMD_WRITE;
        else if (k < 86) cmd = CMD_READ;
        else if (k < 92) cmd = CMD_APPLY;
        else begin
            // odd items: unused command, missing grid, position past the edge
            cmd = 2'($urandom_range(3));
            g = 2'($urandom_range(3));
            c = $urandom_range(127);
            r = $urandom_range(127);
        end
        cell_op(cmd, g, c, r, pick_value());
    endtask

    // small grids only, so every cell in range lies in the filled corner
    task automatic random_config();
        logic [6:0] m [4];
        for (int i = 0; i < 4; i++) begin
            m[i] = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(4));
        end
        // mostly matched periodic pairs, sometimes left half-periodic
        if ($urandom_range(3) != 0) begin
            m[1] = (m[0] == MODE_PERIODIC) ? MODE_PERIODIC
                   : (m[1][2:0] == MODE_PERIODIC) ? MODE_NOSLIP : m[1];
            m[3] = (m[2] == MODE_PERIODIC) ? MODE_PERIODIC
                   : (m[3][2:0] == MODE_PERIODIC) ? MODE_OUTFLOW : m[3];
        end
        set_modes(m[0], m[1], m[2], m[3]);
        case ($urandom_range(7))
            0: write_reg(REG_CELLS_X, 7'd0);
            1: write_reg(REG_CELLS_X, 7'd1);
            default: write_reg(REG_CELLS_X, 7'($urandom_range(2, 8)));
        endcase
        case ($urandom_range(7))
            0: write_reg(REG_CELLS_Y, 7'd0);
            1: write_reg(REG_CELLS_Y, 7'd1);
            default: write_reg(REG_CELLS_Y, 7'($urandom_range(2, 8)));
        endcase
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 22;
        recv_idle_pct = 45;
        span_x = 64;
        span_y = 64;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // fill the corner that small grids use, so no read sees unwritten contents
        for (int g = 0; g < 3; g++)
            for (int j = 0; j < 10; j++)
                for (int i = 0; i < 10; i++)
                    cell_op(CMD_WRITE, 2'(g), i, j, $urandom);

        cell_op(CMD_WRITE, GRID_U, 1, 1, 32'h7fffffff);
        cell_op(CMD_READ, GRID_U, 1, 1, 0);
        cell_op(CMD_WRITE, GRID_V, 1, 1, 32'h80000000);
        cell_op(CMD_READ, GRID_V, 1, 1, 0);
        cell_op(CMD_READ, GRID_P, 127, 0, 0);
        cell_op(CMD_WRITE, GRID_U, 0, 66, 32'h1234);
        cell_op(CMD_READ, GRID_NONE, 0, 0, 0);
        cell_op(2'd3, GRID_U, 5, 5, 32'hffffffff);
        cell_op(CMD_WRITE, GRID_P, 65, 65, 32'h5a5a0001);
        cell_op(CMD_READ, GRID_P, 65, 65, 0);
        write_reg(REG_CELLS_X, 7'd2);
        write_reg(REG_CELLS_Y, 7'd2);
        set_modes(MODE_NOSLIP, MODE_FREESLIP, MODE_OUTFLOW, MODE_NOSLIP);
        cell_op(CMD_APPLY, GRID_U, 0, 0, 0);
        cell_op(CMD_READ, GRID_V, 0, 1, 0);
        cell_op(CMD_READ, GRID_U, 0, 0, 0);
        cell_op(CMD_READ, GRID_U, 3, 3, 0);
        set_modes(MODE_PERIODIC, MODE_NONE, MODE_NONE, MODE_NONE);
        cell_op(CMD_APPLY, GRID_U, 0, 0, 0);
        set_modes(MODE_FREESLIP, MODE_OUTFLOW, MODE_PERIODIC, MODE_FREESLIP);
        cell_op(CMD_APPLY, GRID_U, 0, 0, 0);
        set_modes(MODE_PERIODIC, MODE_PERIODIC, MODE_PERIODIC, MODE_PERIODIC);
        cell_op(CMD_APPLY, GRID_U, 0, 0, 0);
        cell_op(CMD_READ, GRID_V, 3, 1, 0);

        // full width clamped down from 127, short columns
        set_modes(MODE_NONE, MODE_NOSLIP, MODE_NONE, MODE_NONE);
        write_reg(REG_CELLS_X, 7'd127);
        write_reg(REG_CELLS_Y, 7'd0);
        cell_op(CMD_WRITE, GRID_V, 64, 1, 32'h80000000);
        cell_op(CMD_WRITE, GRID_V, 64, 2, 32'h00010000);
        cell_op(CMD_APPLY, GRID_U, 0, 0, 0);
        cell_op(CMD_READ, GRID_U, 64, 2, 0);
        cell_op(CMD_READ, GRID_V, 65, 1, 0);

        // full height with narrow rows
        write_reg(REG_CELLS_X, 7'd0);
        write_reg(REG_CELLS_Y, 7'd64);
        for (int j = 10; j <= 64; j++) begin
            cell_op(CMD_WRITE, GRID_U, 1, j, $urandom);
            cell_op(CMD_WRITE, GRID_V, 2, j, $urandom);
        end
        set_modes(7'd7, MODE_OUTFLOW, 7'd5, MODE_OUTFLOW);
        cell_op(CMD_APPLY, GRID_U, 0, 0, 0);
        cell_op(CMD_READ, GRID_V, 3, 64, 0);
        cell_op(CMD_READ, GRID_U, 2, 64, 0);

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 45;
                recv_idle_pct = 22;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config();
            repeat (150) random_item();
        end

        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_staggered_grid_boundary_apply OK");
        end else begin
            $display("tb_staggered_grid_boundary_apply NOT OK");
        end
        $finish;
    end
endmodule
